[design/llf_pkg.sv]
// Shared types, constants and saturation helpers for the lead-lag filter step block.
package llf_pkg;

    localparam int DATA_W  = 32;             // Q16.16 samples and coefficients
    localparam int DT_W    = 16;             // Q0.16 time step
    localparam int FRAC_W  = 16;             // fractional bits
    localparam int IDX_W   = 3;              // configuration register index
    localparam int NUM_W   = 34;             // numerators and divisor
    localparam int QUO_W   = NUM_W + FRAC_W; // dividend and quotient magnitude
    localparam int REM_W   = NUM_W + 1;      // partial remainder
    localparam int MUL_W   = DATA_W + 1;     // multiplier operand
    localparam int PROD_W  = 64;             // kept product bits
    localparam int ACC_W   = 50;             // output accumulator
    localparam int CNT_W   = 6;              // divider step counter
    localparam int DIV_STEPS = QUO_W;        // one quotient bit per cycle

    localparam logic [IDX_W-1:0] REG_LEAD_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEAD_OFFSET = 3'd1;
    localparam logic [IDX_W-1:0] REG_LAG_GAIN    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LAG_OFFSET  = 3'd3;

    // Which coefficient / filter term the sequencer is working on
    localparam logic [1:0] TERM_A = 2'd0;    // ca, applied to the new sample
    localparam logic [1:0] TERM_B = 2'd1;    // cb, applied to the previous input
    localparam logic [1:0] TERM_C = 2'd2;    // cc, applied to the previous output

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_P2     = 10'b00_0000_0010,
        ST_P4     = 10'b00_0000_0100,
        ST_DEN    = 10'b00_0000_1000,
        ST_DLOAD  = 10'b00_0001_0000,
        ST_DIV    = 10'b00_0010_0000,
        ST_COEF   = 10'b00_0100_0000,
        ST_MULY   = 10'b00_1000_0000,
        ST_ACCY   = 10'b01_0000_0000,
        ST_FINISH = 10'b10_0000_0000
    } llf_state_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(64'sh0000_0000_8000_0000);
    localparam logic [QUO_W-1:0] QMAG_POS = QUO_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [QUO_W-1:0] QMAG_NEG = QUO_W'(64'h0000_0000_8000_0000);

    // Clamp the accumulated output to the signed 32-bit range
    function automatic logic [DATA_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] r;
        begin
            if (v > ACC_MAX)
                r = 32'h7FFF_FFFF;
            else if (v < ACC_MIN)
                r = 32'h8000_0000;
            else
                r = v[DATA_W-1:0];
            return r;
        end
    endfunction

    // Apply the quotient sign and clamp to the signed 32-bit range
    function automatic logic [DATA_W-1:0] sat_coef(input logic neg,
                                                   input logic [QUO_W-1:0] mag);
        logic [DATA_W-1:0] r;
        logic [QUO_W-1:0]  negm;
        begin
            negm = -mag;
            if (neg)
                r = (mag > QMAG_NEG) ? 32'h8000_0000 : negm[DATA_W-1:0];
            else
                r = (mag > QMAG_POS) ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
            return r;
        end
    endfunction

endpackage

[design/lead_lag_filter_step.sv]
// Top level of the first-order lead-lag filter step with a shared multiplier and divider.
// Usage
//   Input channel (in_valid / in_ready): one beat carries a Q16.16 sample and a
//   Q0.16 time step. Output channel (out_valid / out_ready): one beat per input
//   beat carries the filter output, a stepped flag and a divisor_zero flag.
//   Configuration: write cfg_wdata to register cfg_index while cfg_we is high
//   (0 lead_gain, 1 lead_offset, 2 lag_gain, 3 lag_offset; others dropped).
//   Write only while the block is idle.
// Sequence and throughput
//   After a normal input beat the sequencer forms dt*c2, dt*c4 and the divisor on
//   the one 33x33 multiplier, runs three divisions (load, 50 restoring steps,
//   saturate) for ca, cb and cc, then forms and sums the three output terms
//   and finishes. A zero time step goes straight to finish, a zero divisor
//   right after the divisor step. One item is in flight at a time; in_ready
//   returns as out_valid rises, so no new beat is taken before the last result.
// Reset
//   rst_n clears the coefficients, the previous input and output, and out_valid.
// Stalls
//   A finished result waits in the sequencer until the output register is free;
//   in_ready stays low and the filter state holds until it moves across.
module lead_lag_filter_step (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [llf_pkg::IDX_W-1:0]          cfg_index,
    input  logic [llf_pkg::DATA_W-1:0]         cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [llf_pkg::DATA_W-1:0]  sample_in,
    input  logic [llf_pkg::DT_W-1:0]           time_step,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [llf_pkg::DATA_W-1:0]  filtered_out,
    output logic                               stepped,
    output logic                               divisor_zero
);

    localparam int DW = llf_pkg::DATA_W;
    localparam int NW = llf_pkg::NUM_W;
    localparam int QW = llf_pkg::QUO_W;
    localparam int RW = llf_pkg::REM_W;
    localparam int MW = llf_pkg::MUL_W;
    localparam int PW = llf_pkg::PROD_W;
    localparam int AW = llf_pkg::ACC_W;
    localparam int FW = llf_pkg::FRAC_W;
    localparam int CW = llf_pkg::CNT_W;

    // Configuration registers
    logic signed [DW-1:0] lead_gain_reg, lead_offset_reg, lag_gain_reg, lag_offset_reg;

    // Filter state
    logic signed [DW-1:0] last_input_reg, last_output_reg;

    // Sequencer and working registers
    llf_pkg::llf_state_t  state_reg, state_next;
    logic [1:0]           term_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [DW-1:0] u_reg;
    logic [llf_pkg::DT_W-1:0] dt_reg;
    logic                 step_ok_reg, div_zero_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [DW-1:0] p2_reg, p4_reg;
    logic signed [NW-1:0] den_reg;
    logic                 num_neg_reg;
    logic [RW-1:0]        rem_reg;
    logic [QW-1:0]        quo_reg;
    logic signed [DW-1:0] coef_reg [3];
    logic signed [AW-1:0] acc_reg;

    // Output register
    logic                 out_valid_reg;
    logic signed [DW-1:0] out_data_reg;
    logic                 out_stepped_reg, out_dzero_reg;

    // Combinational datapath
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    logic signed [PW-1:0]   prod_shr;
    logic signed [NW-1:0]   twice_c1, twice_c3, p2_ext, p4_ext, den_calc, num_sel;
    logic [NW-1:0]          num_abs, den_abs;
    logic [RW-1:0]          rem_sh;
    logic [RW:0]            rem_diff;
    logic                   rem_ge;
    logic                   out_free;
    logic [DW-1:0]          y_sat;

    assign in_ready     = (state_reg == llf_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign filtered_out = out_data_reg;
    assign stepped      = out_stepped_reg;
    assign divisor_zero = out_dzero_reg;
    assign out_free     = !out_valid_reg || out_ready;

    // Shared multiplier: time step products first, then the three output terms
    always_comb
    begin
        mul_a = {{(MW-llf_pkg::DT_W){1'b0}}, dt_reg};
        mul_b = MW'(lead_offset_reg);
        if (state_reg == llf_pkg::ST_P4)
            mul_b = MW'(lag_offset_reg);
        if (state_reg == llf_pkg::ST_MULY)
        begin
            mul_b = MW'(coef_reg[term_reg]);
            case (term_reg)
                llf_pkg::TERM_A: mul_a = MW'(u_reg);
                llf_pkg::TERM_B: mul_a = MW'(last_input_reg);
                default:         mul_a = MW'(last_output_reg);
            endcase
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_shr = prod_reg >>> FW;

    // Divisor and numerators, all 34-bit signed
    assign twice_c1 = {lead_gain_reg[DW-1], lead_gain_reg, 1'b0};
    assign twice_c3 = {lag_gain_reg[DW-1], lag_gain_reg, 1'b0};
    assign p2_ext   = NW'(p2_reg);
    assign p4_ext   = {{(NW-DW){prod_shr[DW-1]}}, prod_shr[DW-1:0]};
    assign den_calc = twice_c3 + p4_ext;

    always_comb
    begin
        case (term_reg)
            llf_pkg::TERM_A: num_sel = twice_c1 + p2_ext;
            llf_pkg::TERM_B: num_sel = p2_ext - twice_c1;
            default:         num_sel = twice_c3 - NW'(p4_reg);
        endcase
    end

    assign num_abs = num_sel[NW-1] ? NW'(-num_sel) : NW'(num_sel);
    assign den_abs = den_reg[NW-1] ? NW'(-den_reg) : NW'(den_reg);

    // One restoring division step
    assign rem_sh   = {rem_reg[RW-2:0], quo_reg[QW-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, den_abs};
    assign rem_ge   = !rem_diff[RW];

    assign y_sat = llf_pkg::sat_out(acc_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            llf_pkg::ST_IDLE:
                if (in_valid)
                    state_next = (time_step == '0) ? llf_pkg::ST_FINISH : llf_pkg::ST_P2;
            llf_pkg::ST_P2:
                state_next = llf_pkg::ST_P4;
            llf_pkg::ST_P4:
                state_next = llf_pkg::ST_DEN;
            llf_pkg::ST_DEN:
                state_next = (den_calc == '0) ? llf_pkg::ST_FINISH : llf_pkg::ST_DLOAD;
            llf_pkg::ST_DLOAD:
                state_next = llf_pkg::ST_DIV;
            llf_pkg::ST_DIV:
                if (cnt_reg == CW'(llf_pkg::DIV_STEPS - 1))
                    state_next = llf_pkg::ST_COEF;
            llf_pkg::ST_COEF:
                state_next = (term_reg == llf_pkg::TERM_C) ? llf_pkg::ST_MULY
                                                           : llf_pkg::ST_DLOAD;
            llf_pkg::ST_MULY:
                state_next = llf_pkg::ST_ACCY;
            llf_pkg::ST_ACCY:
                state_next = (term_reg == llf_pkg::TERM_C) ? llf_pkg::ST_FINISH
                                                           : llf_pkg::ST_MULY;
            llf_pkg::ST_FINISH:
                if (out_free)
                    state_next = llf_pkg::ST_IDLE;
            default:
                state_next = llf_pkg::ST_IDLE;
        endcase
    end

    // Control state, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= llf_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            lead_gain_reg   <= '0;
            lead_offset_reg <= '0;
            lag_gain_reg    <= '0;
            lag_offset_reg  <= '0;
            last_input_reg  <= '0;
            last_output_reg <= '0;
            term_reg        <= llf_pkg::TERM_A;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    llf_pkg::REG_LEAD_GAIN:   lead_gain_reg   <= cfg_wdata;
                    llf_pkg::REG_LEAD_OFFSET: lead_offset_reg <= cfg_wdata;
                    llf_pkg::REG_LAG_GAIN:    lag_gain_reg    <= cfg_wdata;
                    llf_pkg::REG_LAG_OFFSET:  lag_offset_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            // Load a finished result, else drop the beat once it is taken
            if (state_reg == llf_pkg::ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                llf_pkg::ST_IDLE:
                    term_reg <= llf_pkg::TERM_A;
                llf_pkg::ST_DLOAD:
                    cnt_reg <= '0;
                llf_pkg::ST_DIV:
                    cnt_reg <= cnt_reg + 1'b1;
                llf_pkg::ST_COEF:
                    term_reg <= (term_reg == llf_pkg::TERM_C) ? llf_pkg::TERM_A
                                                              : term_reg + 1'b1;
                llf_pkg::ST_ACCY:
                    term_reg <= term_reg + 1'b1;
                llf_pkg::ST_FINISH:
                    if (out_free && step_ok_reg)
                    begin
                        last_input_reg  <= u_reg;
                        last_output_reg <= y_sat;
                    end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            llf_pkg::ST_IDLE:
                if (in_valid)
                begin
                    u_reg        <= sample_in;
                    dt_reg       <= time_step;
                    step_ok_reg  <= 1'b0;
                    div_zero_reg <= 1'b0;
                    acc_reg      <= '0;
                end
            llf_pkg::ST_P2:
                prod_reg <= mul_p[PW-1:0];
            llf_pkg::ST_P4:
            begin
                p2_reg   <= prod_shr[DW-1:0];
                prod_reg <= mul_p[PW-1:0];
            end
            llf_pkg::ST_DEN:
            begin
                p4_reg       <= prod_shr[DW-1:0];
                den_reg      <= den_calc;
                div_zero_reg <= (den_calc == '0);
                step_ok_reg  <= (den_calc != '0);
            end
            llf_pkg::ST_DLOAD:
            begin
                num_neg_reg <= num_sel[NW-1];
                rem_reg     <= '0;
                quo_reg     <= {num_abs, {FW{1'b0}}};
            end
            llf_pkg::ST_DIV:
            begin
                rem_reg <= rem_ge ? rem_diff[RW-1:0] : rem_sh;
                quo_reg <= {quo_reg[QW-2:0], rem_ge};
            end
            llf_pkg::ST_COEF:
                coef_reg[term_reg] <= llf_pkg::sat_coef(num_neg_reg ^ den_reg[NW-1], quo_reg);
            llf_pkg::ST_MULY:
                prod_reg <= mul_p[PW-1:0];
            llf_pkg::ST_ACCY:
                acc_reg <= acc_reg + {{(AW-PW+FW){prod_shr[PW-FW-1]}}, prod_shr[PW-FW-1:0]};
            llf_pkg::ST_FINISH:
                if (out_free)
                begin
                    out_data_reg    <= step_ok_reg ? y_sat : last_output_reg;
                    out_stepped_reg <= step_ok_reg;
                    out_dzero_reg   <= div_zero_reg;
                end
            default: ;
        endcase
    end

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_stepped_reg && out_dzero_reg))
        else $error("stepped and divisor_zero both set");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == llf_pkg::ST_DIV) |-> (cnt_reg < CW'(llf_pkg::DIV_STEPS)))
        else $error("divider ran past its step count");

    a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stepped_reg) |-> (last_output_reg == out_data_reg))
        else $error("stored output differs from the delivered result");

endmodule
